### src/lbcd_pkg.sv
package lbcd_pkg;

	localparam int SLOTS  = 8;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [2:0] OUT_HIT         = 3'd0;
	localparam logic [2:0] OUT_FILLED      = 3'd1;
	localparam logic [2:0] OUT_NOT_ON_DISK = 3'd2;
	localparam logic [2:0] OUT_BAD_CHANNEL = 3'd3;
	localparam logic [2:0] OUT_READ_FAILED = 3'd4;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// search record handed from cell to cell
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] hit_idx;
		logic              empty;
		logic [SLOT_W-1:0] empty_idx;
		logic [SLOT_W-1:0] best_idx;
		logic [63:0]       best_stamp;
	} scan_pkt_t;

	// slot update broadcast from the controller
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		logic              set_tag;
		logic              valid;
		logic              set_stamp;
		logic [15:0]       channel;
		logic [63:0]       block_num;
		logic [63:0]       stamp;
	} slot_wr_t;

endpackage

### src/lbcd_cell.sv
module lbcd_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lbcd_pkg::SLOT_W-1:0]  cell_idx,
	input  logic [15:0]                  req_channel,
	input  logic [63:0]                  req_block,
	input  lbcd_pkg::scan_pkt_t          pkt_in,
	input  lbcd_pkg::slot_wr_t           wr,
	output lbcd_pkg::scan_pkt_t          pkt_out
);

	logic        valid_q;
	logic [15:0] channel_q;
	logic [63:0] block_q;
	logic [63:0] stamp_q;
	logic        match;
	lbcd_pkg::scan_pkt_t pkt_nx;
	lbcd_pkg::scan_pkt_t pkt_q;

	assign match = valid_q && (channel_q == req_channel) && (block_q == req_block);

	always_comb begin
		pkt_nx = pkt_in;
		if (!pkt_in.hit && match) begin
			pkt_nx.hit     = 1'b1;
			pkt_nx.hit_idx = cell_idx;
		end
		if (!pkt_in.empty && !valid_q) begin
			pkt_nx.empty     = 1'b1;
			pkt_nx.empty_idx = cell_idx;
		end
		if (stamp_q < pkt_in.best_stamp) begin
			pkt_nx.best_idx   = cell_idx;
			pkt_nx.best_stamp = stamp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && wr.idx == cell_idx && wr.set_tag) begin
			valid_q <= wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == cell_idx) begin
			if (wr.set_tag) begin
				channel_q <= wr.channel;
				block_q   <= wr.block_num;
			end
			if (wr.set_stamp) begin
				stamp_q <= wr.stamp;
			end
		end
		pkt_q <= pkt_nx;
	end

	assign pkt_out = pkt_q;

endmodule

### src/lru_block_cache_directory.sv
// channel  direction  handshake                 beat
// in       input      in_valid / in_stall       channel, block_num, block_on_disk, read_ok
// out      output     out_valid / out_stall     outcome, slot, hit_count, miss_count
// config   input      wr_en                     wr_data (open_channels)
//
// a lookup takes the beat in ST_IDLE, then scans in ST_SCAN while the search record
// walks the chain through every cell, then decides and updates a slot in ST_DECIDE.
// a new beat is taken once the previous lookup has been decided, even while
// its result still waits in the output register under out_stall.
// reset empties every slot and clears the tick, counters and open_channels.
module lru_block_cache_directory (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [15:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] channel,
	input  logic [63:0] block_num,
	input  logic        block_on_disk,
	input  logic        read_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  outcome,
	output logic [2:0]  slot,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;
	logic [lbcd_pkg::SLOT_W-1:0] cnt_q;
	logic [15:0] open_q;
	logic [15:0] req_ch_q;
	logic [63:0] req_blk_q;
	logic        req_disk_q;
	logic        req_rdok_q;
	logic [63:0] tick_q;
	logic [31:0] hits_q;
	logic [31:0] misses_q;
	logic        out_valid_q;
	logic [2:0]  outcome_q;
	logic [2:0]  slot_q;

	lbcd_pkg::scan_pkt_t pkt [lbcd_pkg::SLOTS+1];
	lbcd_pkg::scan_pkt_t fin;
	lbcd_pkg::slot_wr_t  wr;

	logic                        accept;
	logic                        decide_go;
	logic [63:0]                 tick_nx;
	logic [63:0]                 tick_d;
	logic [31:0]                 hits_d;
	logic [31:0]                 misses_d;
	logic [2:0]                  outcome_d;
	logic [lbcd_pkg::SLOT_W-1:0] idx_d;
	logic [lbcd_pkg::SLOT_W-1:0] victim;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign decide_go = (state_q == ST_DECIDE) && (!out_valid_q || !out_stall);

	assign pkt[0] = '{hit: 1'b0, hit_idx: '0, empty: 1'b0, empty_idx: '0, best_idx: '0,
		best_stamp: '1};

	for (genvar i = 0; i < lbcd_pkg::SLOTS; i++) begin : g_cell
		lbcd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cell_idx    (lbcd_pkg::SLOT_W'(i)),
			.req_channel (req_ch_q),
			.req_block   (req_blk_q),
			.pkt_in      (pkt[i]),
			.wr          (wr),
			.pkt_out     (pkt[i+1])
		);
	end

	assign fin     = pkt[lbcd_pkg::SLOTS];
	assign tick_nx = tick_q + 64'd1;
	assign victim  = fin.empty ? fin.empty_idx : fin.best_idx;

	always_comb begin
		wr           = '0;
		wr.en        = decide_go;
		wr.channel   = req_ch_q;
		wr.block_num = req_blk_q;
		wr.stamp     = tick_nx;
		tick_d       = tick_q;
		hits_d       = hits_q;
		misses_d     = misses_q;
		outcome_d    = lbcd_pkg::OUT_HIT;
		idx_d        = '0;
		if (fin.hit) begin
			idx_d        = fin.hit_idx;
			wr.idx       = fin.hit_idx;
			wr.set_stamp = 1'b1;
			tick_d       = tick_nx;
			if (hits_q != lbcd_pkg::CNT_MAX) begin
				hits_d = hits_q + 32'd1;
			end
		end else begin
			if (misses_q != lbcd_pkg::CNT_MAX) begin
				misses_d = misses_q + 32'd1;
			end
			if (!req_disk_q) begin
				outcome_d = lbcd_pkg::OUT_NOT_ON_DISK;
			end else if (req_ch_q >= open_q) begin
				outcome_d = lbcd_pkg::OUT_BAD_CHANNEL;
			end else begin
				idx_d      = victim;
				wr.idx     = victim;
				wr.set_tag = 1'b1;
				if (req_rdok_q) begin
					outcome_d    = lbcd_pkg::OUT_FILLED;
					wr.valid     = 1'b1;
					wr.set_stamp = 1'b1;
					tick_d       = tick_nx;
				end else begin
					outcome_d = lbcd_pkg::OUT_READ_FAILED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			open_q      <= '0;
			tick_q      <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				open_q <= wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lbcd_pkg::SLOT_W'(lbcd_pkg::SLOTS - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (decide_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (decide_go) begin
				tick_q      <= tick_d;
				hits_q      <= hits_d;
				misses_q    <= misses_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_ch_q   <= channel;
			req_blk_q  <= block_num;
			req_disk_q <= block_on_disk;
			req_rdok_q <= read_ok;
		end
		if (decide_go) begin
			outcome_q <= outcome_d;
			slot_q    <= 3'(idx_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign outcome    = outcome_q;
	assign slot       = slot_q;
	assign hit_count  = hits_q;
	assign miss_count = misses_q;

endmodule
